/* rtl/ppu_pkg.sv */
// Shared widths, vertex and payload types for the polyline perimeter unit.
`timescale 1ns / 1ps

package ppu_pkg;

    localparam int COORD_BITS = 24;
    localparam int TOTAL_BITS = 48;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ROOT_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * ROOT_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
        logic                         last_point;
    } in_req_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] perimeter;
        logic                  saturated;
        logic                  too_few_points;
    } out_req_t;

endpackage

/* rtl/ppu_sqrt.sv */
// Iterative digit-by-digit floor square root, one root bit per cycle.
`timescale 1ns / 1ps

module ppu_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ppu_pkg::SQ_BITS-1:0]      radicand,
    output logic                             done,
    output logic [ppu_pkg::ROOT_BITS-1:0]    root
);

    localparam int R      = ppu_pkg::ROOT_BITS;
    localparam int CNT_W  = $clog2(R + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [2*R-1:0]          op_reg, op_next;
    logic [R+1:0]            rem_reg, rem_next;
    logic [R-1:0]            root_reg, root_next;
    logic [R+3:0]            rem_shift;
    logic [R+3:0]            trial;
    logic [R+3:0]            rem_diff;

    // One restoring step: bring down two radicand bits and try a 1 digit.
    assign rem_shift = {rem_reg, op_reg[2*R-1:2*R-2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(R);
            op_next   = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            op_next  = {op_reg[2*R-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= trial)
            begin
                rem_next  = rem_diff[R+1:0];
                root_next = {root_reg[R-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[R+1:0];
                root_next = {root_reg[R-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/ppu_edge.sv */
// Edge length unit: squares the three axis differences on one multiplier,
// sums them and takes the floor square root.
`timescale 1ns / 1ps

module ppu_edge (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  ppu_pkg::vertex_t                 vert_a,
    input  ppu_pkg::vertex_t                 vert_b,
    output logic                             done,
    output logic [ppu_pkg::ROOT_BITS-1:0]    len
);

    localparam int C     = ppu_pkg::COORD_BITS;
    localparam int D     = ppu_pkg::DIFF_BITS;
    localparam int S     = ppu_pkg::SQ_BITS;
    localparam logic [2:0] AXIS_X    = 3'd0;
    localparam logic [2:0] AXIS_Y    = 3'd1;
    localparam logic [2:0] AXIS_Z    = 3'd2;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic            sq_busy_reg, sq_busy_next;
    logic            root_start_reg, root_start_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [D-1:0]    diff_reg, diff_next;
    logic [S-1:0]    prod_reg, prod_next;
    logic [S-1:0]    sum_reg, sum_next;
    logic [C-1:0]    sel_a, sel_b;
    logic signed [D-1:0] sdiff;
    logic            axis_valid;

    always_comb
    begin
        sel_a      = vert_a.x;
        sel_b      = vert_b.x;
        axis_valid = 1'b1;
        case (cnt_reg)
            AXIS_X:
            begin
                sel_a = vert_a.x;
                sel_b = vert_b.x;
            end
            AXIS_Y:
            begin
                sel_a = vert_a.y;
                sel_b = vert_b.y;
            end
            AXIS_Z:
            begin
                sel_a = vert_a.z;
                sel_b = vert_b.z;
            end
            default:
            begin
                axis_valid = 1'b0;
            end
        endcase
    end

    assign sdiff = $signed({sel_b[C-1], sel_b}) - $signed({sel_a[C-1], sel_a});

    // Difference, square and sum form a three-stage pipe over the axes.
    always_comb
    begin
        sq_busy_next    = sq_busy_reg;
        root_start_next = 1'b0;
        cnt_next        = cnt_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        if (start)
        begin
            sq_busy_next = 1'b1;
            cnt_next     = AXIS_X;
            diff_next    = '0;
            prod_next    = '0;
            sum_next     = '0;
        end
        else if (sq_busy_reg)
        begin
            if (!axis_valid)
                diff_next = '0;
            else if (sdiff[D-1])
                diff_next = D'(-sdiff);
            else
                diff_next = D'(sdiff);
            prod_next = S'(diff_reg * diff_reg);
            sum_next  = sum_reg + prod_reg;
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == LAST_STEP)
            begin
                sq_busy_next    = 1'b0;
                root_start_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg    <= 1'b0;
            root_start_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            sq_busy_reg    <= sq_busy_next;
            root_start_reg <= root_start_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    ppu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start_reg),
        .radicand (sum_reg),
        .done     (done),
        .root     (len)
    );

endmodule

/* rtl/polyline_perimeter_unit.sv */
// Top level of the polyline perimeter unit: path sequencer, accumulator and ports.
`timescale 1ns / 1ps

// The unit takes 3D vertices in signed fixed point, one request at a time,
// and returns one total path length for each path, on the request that
// carries last_point. Each edge is the floor square root of the summed
// squared axis differences; the three squares share one multiplier in a
// pipe of difference, square and sum registers, and the root is built one
// bit per cycle by a shift-subtract unit. A vertex that adds an edge holds
// in_ready low while its edges are computed and accumulated, so the unit
// takes no new vertex while an edge is in flight. The first vertex of a
// path starts no edge. When closed_path is set, the last vertex also
// computes the closing edge back to the first vertex, and every last
// vertex then moves its total into the output register from a done state.
// The total saturates at its all-ones maximum and then reports saturated.
// A one-vertex path reports zero with too_few_points. The result sits in
// an output register, so the next path can start while a finished result
// waits for out_ready. closed_path must be written through the cfg channel
// only while the unit is idle; the block itself does not enforce it.
module polyline_perimeter_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppu_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ppu_pkg::out_req_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int T     = ppu_pkg::TOTAL_BITS;
    localparam int R     = ppu_pkg::ROOT_BITS;
    localparam int SUM_W = ((T > R) ? T : R) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EDGE1 = 2'd1;
    localparam logic [1:0] ST_EDGE2 = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                have_first_reg, have_first_next;
    logic                last_reg, last_next;
    logic                too_few_reg, too_few_next;
    logic                sat_reg, sat_next;
    logic                closed_reg, closed_next;
    logic                edge_start_reg, edge_start_next;
    logic                out_valid_reg, out_valid_next;
    logic [T-1:0]        total_reg, total_next;
    ppu_pkg::vertex_t    first_reg, first_next;
    ppu_pkg::vertex_t    prev_reg, prev_next;
    ppu_pkg::vertex_t    cur_reg, cur_next;
    ppu_pkg::out_req_t   out_reg, out_next;
    ppu_pkg::vertex_t    in_vert;
    ppu_pkg::vertex_t    edge_a, edge_b;
    logic                edge_done;
    logic [R-1:0]        edge_len;
    logic [SUM_W-1:0]    acc_sum;
    logic                acc_ovf;
    logic [T-1:0]        acc_total;
    logic                in_take;

    assign in_vert.x = in_data.x_coord;
    assign in_vert.y = in_data.y_coord;
    assign in_vert.z = in_data.z_coord;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // The path edge runs from previous to current vertex; the closing edge
    // runs from current back to the first vertex.
    assign edge_a = (state_reg == ST_EDGE2) ? cur_reg : prev_reg;
    assign edge_b = (state_reg == ST_EDGE2) ? first_reg : cur_reg;

    ppu_edge u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (edge_start_reg),
        .vert_a (edge_a),
        .vert_b (edge_b),
        .done   (edge_done),
        .len    (edge_len)
    );

    // Saturating accumulate: any carry past the total width clamps to all ones.
    assign acc_sum   = SUM_W'(total_reg) + SUM_W'(edge_len);
    assign acc_ovf   = (acc_sum[SUM_W-1:T] != '0);
    assign acc_total = acc_ovf ? {T{1'b1}} : acc_sum[T-1:0];

    always_comb
    begin
        state_next      = state_reg;
        have_first_next = have_first_reg;
        last_next       = last_reg;
        too_few_next    = too_few_reg;
        sat_next        = sat_reg;
        closed_next     = closed_reg;
        edge_start_next = 1'b0;
        out_valid_next  = out_valid_reg;
        total_next      = total_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        out_next        = out_reg;

        if (cfg_valid && cfg_ready)
            closed_next = cfg_data;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cur_next  = in_vert;
                    last_next = in_data.last_point;
                    if (!have_first_reg)
                    begin
                        first_next      = in_vert;
                        prev_next       = in_vert;
                        have_first_next = 1'b1;
                        if (in_data.last_point)
                        begin
                            too_few_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                    end
                    else
                    begin
                        edge_start_next = 1'b1;
                        state_next      = ST_EDGE1;
                    end
                end
            end
            ST_EDGE1:
            begin
                if (edge_done)
                begin
                    total_next = acc_total;
                    sat_next   = sat_reg | acc_ovf;
                    prev_next  = cur_reg;
                    if (!last_reg)
                        state_next = ST_IDLE;
                    else if (closed_reg)
                    begin
                        edge_start_next = 1'b1;
                        state_next      = ST_EDGE2;
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_EDGE2:
            begin
                if (edge_done)
                begin
                    total_next = acc_total;
                    sat_next   = sat_reg | acc_ovf;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait for the output register to free up, then clear the path.
                if (!out_valid_reg || out_ready)
                begin
                    out_next.perimeter      = too_few_reg ? '0 : total_reg;
                    out_next.saturated      = too_few_reg ? 1'b0 : sat_reg;
                    out_next.too_few_points = too_few_reg;
                    out_valid_next          = 1'b1;
                    total_next              = '0;
                    sat_next                = 1'b0;
                    too_few_next            = 1'b0;
                    have_first_next         = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_first_reg <= 1'b0;
            last_reg       <= 1'b0;
            too_few_reg    <= 1'b0;
            sat_reg        <= 1'b0;
            closed_reg     <= 1'b0;
            edge_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
            last_reg       <= last_next;
            too_few_reg    <= too_few_next;
            sat_reg        <= sat_next;
            closed_reg     <= closed_next;
            edge_start_reg <= edge_start_next;
            out_valid_reg  <= out_valid_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // An edge result only arrives while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_done |-> (state_reg == ST_EDGE1 || state_reg == ST_EDGE2))
        else $error("edge result outside an edge state");

    // A short path reports a zero total without saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.too_few_points) |->
            (out_reg.perimeter == '0 && !out_reg.saturated))
        else $error("short path result carries a length");

    // A saturated total must be pinned at the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.saturated) |-> (&out_reg.perimeter))
        else $error("saturated total below maximum");

    // A request that adds an edge starts the edge unit on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && have_first_reg) |=> (edge_start_reg && state_reg == ST_EDGE1))
        else $error("edge not started after request");

endmodule
